// ===== rtl/connection_pool_free_list_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef CONNECTION_POOL_FREE_LIST_MACROS_SVH
`define CONNECTION_POOL_FREE_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define CPFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("connection pool free list check failed");

// Next-cycle implication, sampled on clk and off while rst is high.
`define CPFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("connection pool free list check failed");

`endif

// ===== rtl/cpfl_pkg.sv =====
package cpfl_pkg;

  localparam int POOL_SIZE_DEF = 1024;

  localparam int DESC_W   = 16;
  localparam int SLOT_W   = 10;
  localparam int SEQ_W    = 64;
  localparam int COUNT_W  = 11;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 88;

  localparam logic REQ_GET  = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Access strobes from the controller to the slot store.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

// ===== rtl/cpfl_slot_store.sv =====
module cpfl_slot_store #(
  parameter int POOL_SIZE = cpfl_pkg::POOL_SIZE_DEF,
  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
  localparam int IDX_W = $clog2(POOL_SIZE + 1),
  localparam int EW = cpfl_pkg::DESC_W + cpfl_pkg::SEQ_W + 1 + IDX_W
) (
  input  logic               clk,
  input  logic               rst,
  input  cpfl_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  input  logic [EW-1:0]      wr_data,
  output logic [EW-1:0]      rd_data,
  output logic               busy
);
  import cpfl_pkg::*;

  logic [EW-1:0] mem [POOL_SIZE];
  logic [AW-1:0] clr_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic [IDX_W-1:0] clr_link;

  // The sweep rebuilds the initial chain: each entry links to the next,
  // instance set, sequence and descriptor zero.
  assign clr_link = IDX_W'(clr_addr) + IDX_W'(1);

  always_comb begin
    we = busy | cmd.wr;
    wa = busy ? clr_addr : wr_addr;
    wd = busy ? {{(DESC_W + SEQ_W){1'b0}}, 1'b1, clr_link} : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(POOL_SIZE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/connection_pool_free_list.sv =====
// m_tvalid is registered: it rises once the modify step commits, which waits until m_* is free.
// Each request is read, then modified and written back in the slot memory before the next is taken.
// A result waiting on m_tready holds the next request in its modify cycle until taken.
// Reset (rst, synchronous): control clears at once, then a sweep over every entry
// rebuilds the free chain in the slot memory; s_tready stays low during the sweep.
module connection_pool_free_list #(
  parameter int POOL_SIZE = cpfl_pkg::POOL_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // descriptor [15:0], slot_index [25:16], zero fill [31:26]
  input  logic [cpfl_pkg::S_DATA_W-1:0]   s_tdata,
  // req_type [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // granted_slot [9:0], instance_bit [10], sequence_res [74:11],
  // free_slots [85:75], zero fill [87:86]
  output logic [cpfl_pkg::M_DATA_W-1:0]   m_tdata,
  // status [0]
  output logic                            m_tuser
);
  import cpfl_pkg::*;

  // Address width of the slot memory, and width of a slot number that can
  // also hold the end-of-list marker (POOL_SIZE).
  localparam int AW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int IDX_W = $clog2(POOL_SIZE + 1);
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int EW    = DESC_W + SEQ_W + 1 + IDX_W;

  // Layout of one memory word, from the lowest bit: next link, instance
  // bit, sequence number, descriptor.
  localparam int INST_B = IDX_W;
  localparam int SEQ_LO = IDX_W + 1;
  localparam int DSC_LO = SEQ_LO + SEQ_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  logic             state;
  logic             req_q;
  logic             reject_q;
  logic [DESC_W-1:0] desc_q;
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] free_head;
  logic [CNT_W-1:0] free_count;

  logic             out_status;
  logic [SLOT_W-1:0] out_slot;
  logic             out_inst;
  logic [SEQ_W-1:0] out_seq;
  logic [COUNT_W-1:0] out_count;

  mem_cmd_t         cmd;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    rd_data;
  logic             busy;

  logic             in_beat;
  logic             in_get;
  logic             pool_empty;
  logic             slot_ok;
  logic [31:0]      slot_wide;
  logic [31:0]      head_wide;
  logic             out_free;
  logic             commit;

  logic [IDX_W-1:0] old_link;
  logic             old_inst;
  logic [SEQ_W-1:0] seq_inc;
  logic [DESC_W-1:0] old_desc;
  logic             new_inst;
  logic [IDX_W-1:0] new_link;
  logic [DESC_W-1:0] new_desc;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] head_next;
  logic [31:0]      gslot_wide;
  logic [31:0]      count_wide;

  // Requests are taken one at a time, and only once the chain is rebuilt.
  assign s_tready = (state == ST_IDLE) && !busy;
  assign in_beat  = s_tvalid && s_tready;
  assign in_get   = (s_tuser == REQ_GET);

  assign slot_wide  = 32'(s_tdata[DESC_W +: SLOT_W]);
  assign head_wide  = 32'(free_head);
  assign pool_empty = (free_count == '0) || (head_wide >= 32'(POOL_SIZE));
  assign slot_ok    = slot_wide < 32'(POOL_SIZE);

  // The slot entry is read on the accept edge; it is modified and written
  // back in the modify state once m_* is free, before the next request may read.
  assign rd_addr = in_get ? free_head[AW-1:0] : slot_wide[AW-1:0];
  assign cmd.rd  = in_beat;

  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == ST_MOD) && out_free;
  assign cmd.wr   = commit && !reject_q;

  always_comb begin
    old_link = rd_data[IDX_W-1:0];
    old_inst = rd_data[INST_B];
    seq_inc  = rd_data[SEQ_LO +: SEQ_W] + SEQ_W'(1);
    old_desc = rd_data[DSC_LO +: DESC_W];

    if (req_q == REQ_GET) begin
      // Pop: the slot leaves the list, its instance flips and the new
      // descriptor is bound to it.
      new_inst   = !old_inst;
      new_link   = old_link;
      new_desc   = desc_q;
      head_next  = old_link;
      count_next = free_count - CNT_W'(1);
    end else begin
      // Push: the slot links to the old head and becomes the head. The
      // count saturates, since double frees are not caught.
      new_inst   = old_inst;
      new_link   = free_head;
      new_desc   = old_desc;
      head_next  = slot_q;
      count_next = (free_count < CNT_W'(POOL_SIZE)) ? free_count + CNT_W'(1)
                                                    : free_count;
    end
    wr_data = {new_desc, seq_inc, new_inst, new_link};
  end

  assign gslot_wide = 32'(slot_q);
  assign count_wide = reject_q ? 32'(free_count) : 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_head  <= '0;
      free_count <= CNT_W'(POOL_SIZE);
      m_tvalid   <= 1'b0;
    end else begin
      // A new result takes the output register in the same cycle the old
      // one leaves, so the set wins over the clear.
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (commit) begin
            state <= ST_IDLE;
            if (!reject_q) begin
              free_head  <= head_next;
              free_count <= count_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request payload, held for the modify cycle.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_q  <= s_tuser;
      desc_q <= s_tdata[DESC_W-1:0];
      if (in_get) begin
        slot_q   <= free_head;
        reject_q <= pool_empty;
      end else begin
        slot_q   <= slot_wide[IDX_W-1:0];
        reject_q <= !slot_ok;
      end
    end
  end

  // Result register. A rejected get reports slot zero; a rejected free
  // echoes the slot it was given.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_count <= count_wide[COUNT_W-1:0];
      if (reject_q) begin
        out_status <= STATUS_EMPTY;
        out_slot   <= (req_q == REQ_GET) ? '0 : gslot_wide[SLOT_W-1:0];
        out_inst   <= 1'b0;
        out_seq    <= '0;
      end else begin
        out_status <= STATUS_DONE;
        out_slot   <= gslot_wide[SLOT_W-1:0];
        out_inst   <= new_inst;
        out_seq    <= seq_inc;
      end
    end
  end

  assign m_tdata = {2'b00, out_count, out_seq, out_inst, out_slot};
  assign m_tuser = out_status;

  cpfl_slot_store #(
    .POOL_SIZE (POOL_SIZE)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (slot_q[AW-1:0]),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .busy    (busy)
  );

  `include "connection_pool_free_list_macros.svh"

  // No request may slip in while the chain is still being rebuilt.
  `CPFL_ASSERT_NOW(a_no_accept_in_sweep, busy, !s_tready)
  // A committed modify always leaves a result beat on the master side.
  `CPFL_ASSERT_NEXT(a_commit_gives_beat, commit, m_tvalid && (state == ST_IDLE))
  // The free count never runs past the pool.
  `CPFL_ASSERT_NOW(a_count_bound, 1'b1, free_count <= CNT_W'(POOL_SIZE))
  // A successful get always lowers the free count by one.
  `CPFL_ASSERT_NEXT(a_get_takes_one, commit && !reject_q && (req_q == REQ_GET),
    free_count == $past(free_count) - CNT_W'(1))

endmodule
